// ===== src/nmea_gga_gsa_field_extractor_unit_assert.svh =====
// Assertion macros for the NMEA field extractor.
`ifndef NMEA_GGA_GSA_FIELD_EXTRACTOR_UNIT_ASSERT_SVH
`define NMEA_GGA_GSA_FIELD_EXTRACTOR_UNIT_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define NGFX_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("NMEA extractor check failed");
// Next-cycle implication, checked outside reset.
`define NGFX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("NMEA extractor check failed");
`else
`define NGFX_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define NGFX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/ngfx_pkg.sv =====
`default_nettype none

package ngfx_pkg;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
    localparam logic [7:0] CHAR_COMMA   = 8'h2C;
    localparam logic [7:0] CHAR_G       = 8'h47;
    localparam logic [7:0] CHAR_P       = 8'h50;
    localparam logic [7:0] CHAR_S       = 8'h53;
    localparam logic [7:0] CHAR_A       = 8'h41;
    localparam logic [7:0] DIGIT_BIAS   = 8'h30;

    localparam logic [7:0] FIELD_TIME      = 8'd1;
    localparam logic [7:0] FIELD_AFTER_TIME = 8'd2;
    localparam logic [7:0] FIELD_SATS      = 8'd7;
    localparam logic [7:0] FIELD_AFTER_SATS = 8'd8;
    localparam logic [7:0] FIELD_FIX       = 8'd2;

    localparam logic [3:0] CHAR_INDEX_MAX = 4'd15;
    localparam logic [7:0] LOCK_NONE      = 8'd1;

    typedef enum logic [1:0] {
        KIND_TIME      = 2'd0,
        KIND_TIME_NOLOCK = 2'd1,
        KIND_SATS      = 2'd2,
        KIND_LOCK      = 2'd3
    } result_kind_t;

endpackage

`default_nettype wire

// ===== src/nmea_gga_gsa_field_extractor_unit.sv =====
// A byte accepted on s_* is held in the input register; its result (if any) is then registered on m_*.
// Throughput: one byte per cycle while m_ready is high; the input register takes a new byte
// while the result register is held, so the stream only stops when both are full and m_ready is low.
// Reset (aresetn low, synchronous): sentence state idle, field count and character
// index zero, character store cleared to zero, lock value one, both stages empty.
`default_nettype none

`include "nmea_gga_gsa_field_extractor_unit_assert.svh"

module nmea_gga_gsa_field_extractor_unit #(
    parameter int STORE_DEPTH = 9
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_result_kind,
    output logic [47:0]      m_time_chars,
    output logic [15:0]      m_sat_chars,
    output logic [1:0]       m_lock_state
);

    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam logic [4:0] DEPTH_L = 5'(STORE_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_CMD  = 2'd1,
        ST_GGA  = 2'd2,
        ST_GSA  = 2'd3
    } sent_state_t;

    sent_state_t sent_state_reg, sent_state_next;
    logic [7:0]  field_count_reg, field_count_next;
    logic [3:0]  char_index_reg, char_index_next;
    logic [7:0]  lock_value_reg, lock_value_next;
    logic [7:0]  store_reg [STORE_DEPTH];

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    logic [1:0]  out_kind_reg;
    logic [47:0] out_time_reg;
    logic [15:0] out_sat_reg;
    logic [1:0]  out_lock_reg;

    logic        adv;
    logic        wr_en;
    logic        res_valid;
    logic [1:0]  res_kind;
    logic [47:0] res_time;
    logic [15:0] res_sat;
    logic [1:0]  res_lock;
    logic [47:0] time_now;

    assign adv     = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;

    assign m_valid       = out_valid_reg;
    assign m_result_kind = out_kind_reg;
    assign m_time_chars  = out_time_reg;
    assign m_sat_chars   = out_sat_reg;
    assign m_lock_state  = out_lock_reg;

    assign time_now = {store_reg[0], store_reg[1], store_reg[2],
                       store_reg[3], store_reg[4], store_reg[5]};

    always_comb begin
        sent_state_next  = sent_state_reg;
        field_count_next = field_count_reg;
        char_index_next  = char_index_reg;
        lock_value_next  = lock_value_reg;
        wr_en     = 1'b0;
        res_valid = 1'b0;
        res_kind  = ngfx_pkg::KIND_TIME;
        res_time  = '0;
        res_sat   = '0;
        res_lock  = '0;

        if (in_byte_reg == ngfx_pkg::CHAR_NEWLINE) begin
            sent_state_next  = ST_IDLE;
            field_count_next = '0;
            char_index_next  = '0;
            lock_value_next  = ngfx_pkg::LOCK_NONE;
        end else if (in_byte_reg == ngfx_pkg::CHAR_DOLLAR) begin
            sent_state_next = ST_CMD;
        end else if (in_byte_reg == ngfx_pkg::CHAR_COMMA) begin
            field_count_next = field_count_reg + 8'd1;
            char_index_next  = '0;
            if (sent_state_reg == ST_CMD) begin
                // Only commands that begin GPGGA or GPGSA are followed; others drop to idle.
                if (store_reg[0] == ngfx_pkg::CHAR_G && store_reg[1] == ngfx_pkg::CHAR_P &&
                    store_reg[2] == ngfx_pkg::CHAR_G && store_reg[4] == ngfx_pkg::CHAR_A &&
                    store_reg[3] == ngfx_pkg::CHAR_G) begin
                    sent_state_next = ST_GGA;
                end else if (store_reg[0] == ngfx_pkg::CHAR_G &&
                             store_reg[1] == ngfx_pkg::CHAR_P &&
                             store_reg[2] == ngfx_pkg::CHAR_G &&
                             store_reg[4] == ngfx_pkg::CHAR_A &&
                             store_reg[3] == ngfx_pkg::CHAR_S) begin
                    sent_state_next = ST_GSA;
                end else begin
                    sent_state_next = ST_IDLE;
                end
            end else if (sent_state_reg == ST_GGA && lock_value_reg == ngfx_pkg::LOCK_NONE &&
                         field_count_next == ngfx_pkg::FIELD_AFTER_TIME &&
                         store_reg[0] != ngfx_pkg::CHAR_G) begin
                res_valid = 1'b1;
                res_kind  = ngfx_pkg::KIND_TIME_NOLOCK;
                res_time  = time_now;
            end
        end else if (sent_state_reg == ST_CMD ||
                     (sent_state_reg == ST_GGA &&
                      (field_count_reg == ngfx_pkg::FIELD_TIME ||
                       field_count_reg == ngfx_pkg::FIELD_SATS))) begin
            wr_en = ({1'b0, char_index_reg} < DEPTH_L);
            if (char_index_reg < ngfx_pkg::CHAR_INDEX_MAX) begin
                char_index_next = char_index_reg + 4'd1;
            end
        end else if (sent_state_reg == ST_GGA) begin
            if (field_count_reg == ngfx_pkg::FIELD_AFTER_TIME) begin
                res_valid = 1'b1;
                res_kind  = ngfx_pkg::KIND_TIME;
                res_time  = time_now;
            end else if (field_count_reg == ngfx_pkg::FIELD_AFTER_SATS) begin
                res_valid = 1'b1;
                res_kind  = ngfx_pkg::KIND_SATS;
                res_sat   = {store_reg[0], store_reg[1]};
            end
        end else if (sent_state_reg == ST_GSA && field_count_reg == ngfx_pkg::FIELD_FIX) begin
            lock_value_next = in_byte_reg - ngfx_pkg::DIGIT_BIAS;
            // A fix digit outside 1..3 is kept but not reported.
            if (lock_value_next[7:2] == 6'd0 && lock_value_next[1:0] != 2'd0) begin
                res_valid = 1'b1;
                res_kind  = ngfx_pkg::KIND_LOCK;
                res_lock  = lock_value_next[1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sent_state_reg  <= ST_IDLE;
            field_count_reg <= '0;
            char_index_reg  <= '0;
            lock_value_reg  <= ngfx_pkg::LOCK_NONE;
            for (int i = 0; i < STORE_DEPTH; i++) begin
                store_reg[i] <= '0;
            end
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
                in_byte_reg  <= s_rx_byte;
            end else if (adv) begin
                in_valid_reg <= 1'b0;
            end

            if (m_ready) begin
                out_valid_reg <= 1'b0;
            end

            if (adv) begin
                sent_state_reg  <= sent_state_next;
                field_count_reg <= field_count_next;
                char_index_reg  <= char_index_next;
                lock_value_reg  <= lock_value_next;
                if (wr_en) begin
                    store_reg[char_index_reg[IDX_W-1:0]] <= in_byte_reg;
                end
                if (res_valid) begin
                    out_valid_reg <= 1'b1;
                    out_kind_reg  <= res_kind;
                    out_time_reg  <= res_time;
                    out_sat_reg   <= res_sat;
                    out_lock_reg  <= res_lock;
                end
            end
        end
    end

    `NGFX_ASSERT_NOW(a_lock_kind_has_value, aclk, aresetn, m_valid && m_result_kind == ngfx_pkg::KIND_LOCK, m_lock_state != 2'd0)
    `NGFX_ASSERT_NOW(a_other_kind_no_lock, aclk, aresetn, m_valid && m_result_kind != ngfx_pkg::KIND_LOCK, m_lock_state == 2'd0)
    `NGFX_ASSERT_NEXT(a_newline_clears, aclk, aresetn, adv && in_byte_reg == ngfx_pkg::CHAR_NEWLINE, sent_state_reg == ST_IDLE && field_count_reg == 8'd0 && char_index_reg == 4'd0)
    `NGFX_ASSERT_NOW(a_stall_only_on_full, aclk, aresetn, !s_ready, in_valid_reg && out_valid_reg && !m_ready)

endmodule

`default_nettype wire

// ===== sim/nmea_gga_gsa_field_extractor_unit_tb.sv =====
`default_nettype none

module nmea_gga_gsa_field_extractor_unit_tb;

    localparam int STORE_DEPTH = 9;
    localparam int RANDOM_ITEMS = 850;
    localparam int HOLD_CYCLES = 80;

    typedef enum logic [1:0] {
        SENT_IDLE = 2'd0,
        SENT_CMD  = 2'd1,
        SENT_GGA  = 2'd2,
        SENT_GSA  = 2'd3
    } sentence_t;

    typedef struct packed {
        ngfx_pkg::result_kind_t kind;
        logic [47:0]            time_chars;
        logic [15:0]            sat_chars;
        logic [1:0]             lock_state;
    } nmea_result_t;

    // Tracks the sentence parser and holds the results it still owes.
    class nmea_result_board;
        sentence_t    sentence;
        logic [7:0]   fields;
        logic [3:0]   idx;
        logic [7:0]   store [STORE_DEPTH];
        logic [7:0]   lock;
        nmea_result_t owed [$];
        int           mismatches;

        function new();
            sentence = SENT_IDLE;
            fields = '0;
            idx = '0;
            foreach (store[i]) store[i] = '0;
            lock = ngfx_pkg::LOCK_NONE;
            mismatches = 0;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function void note_input(logic [7:0] b);
            nmea_result_t r;
            bit           hit;
            bit           gpg_a;
            hit = 1'b0;
            r = '0;
            if (b == ngfx_pkg::CHAR_NEWLINE) begin
                sentence = SENT_IDLE;
                fields = '0;
                idx = '0;
                lock = ngfx_pkg::LOCK_NONE;
            end else if (b == ngfx_pkg::CHAR_DOLLAR) begin
                sentence = SENT_CMD;
            end else if (b == ngfx_pkg::CHAR_COMMA) begin
                fields = fields + 8'd1;
                idx = '0;
                if (sentence == SENT_CMD) begin
                    gpg_a = store[0] == ngfx_pkg::CHAR_G && store[1] == ngfx_pkg::CHAR_P &&
                            store[2] == ngfx_pkg::CHAR_G && store[4] == ngfx_pkg::CHAR_A;
                    if (gpg_a && store[3] == ngfx_pkg::CHAR_G)
                        sentence = SENT_GGA;
                    else if (gpg_a && store[3] == ngfx_pkg::CHAR_S)
                        sentence = SENT_GSA;
                    else
                        sentence = SENT_IDLE;
                end else if (sentence == SENT_GGA && lock == ngfx_pkg::LOCK_NONE &&
                             fields == ngfx_pkg::FIELD_AFTER_TIME &&
                             store[0] != ngfx_pkg::CHAR_G) begin
                    hit = 1'b1;
                    r.kind = ngfx_pkg::KIND_TIME_NOLOCK;
                    r.time_chars = {store[0], store[1], store[2],
                                    store[3], store[4], store[5]};
                end
            end else if (sentence == SENT_CMD || (sentence == SENT_GGA &&
                         (fields == ngfx_pkg::FIELD_TIME ||
                          fields == ngfx_pkg::FIELD_SATS))) begin
                // Writes past the end of the store are dropped.
                if (int'(idx) < STORE_DEPTH)
                    store[idx] = b;
                if (idx < ngfx_pkg::CHAR_INDEX_MAX)
                    idx = idx + 4'd1;
            end else if (sentence == SENT_GGA) begin
                if (fields == ngfx_pkg::FIELD_AFTER_TIME) begin
                    hit = 1'b1;
                    r.kind = ngfx_pkg::KIND_TIME;
                    r.time_chars = {store[0], store[1], store[2],
                                    store[3], store[4], store[5]};
                end else if (fields == ngfx_pkg::FIELD_AFTER_SATS) begin
                    hit = 1'b1;
                    r.kind = ngfx_pkg::KIND_SATS;
                    r.sat_chars = {store[0], store[1]};
                end
            end else if (sentence == SENT_GSA && fields == ngfx_pkg::FIELD_FIX) begin
                lock = b - ngfx_pkg::DIGIT_BIAS;
                if (lock >= 8'd1 && lock <= 8'd3) begin
                    hit = 1'b1;
                    r.kind = ngfx_pkg::KIND_LOCK;
                    r.lock_state = lock[1:0];
                end
            end
            if (hit)
                owed.push_back(r);
        endfunction

        function void check_result(logic [1:0] kind, logic [47:0] tc,
                                   logic [15:0] sc, logic [1:0] ls);
            nmea_result_t want;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0d time %h sats %h lock %0d",
                             kind, tc, sc, ls);
                return;
            end
            want = owed.pop_front();
            if (kind !== want.kind || tc !== want.time_chars ||
                sc !== want.sat_chars || ls !== want.lock_state) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected kind %0d time %h sats %h lock %0d, ",
                              "got kind %0d time %h sats %h lock %0d"},
                             want.kind, want.time_chars, want.sat_chars, want.lock_state,
                             kind, tc, sc, ls);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_result_kind;
    logic [47:0] m_time_chars;
    logic [15:0] m_sat_chars;
    logic [1:0]  m_lock_state;

    bit          steady;
    bit          hold_request;
    logic [7:0]  byte_plan [$];
    nmea_result_board board;

    nmea_gga_gsa_field_extractor_unit #(
        .STORE_DEPTH(STORE_DEPTH)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_rx_byte(s_rx_byte),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_result_kind(m_result_kind),
        .m_time_chars(m_time_chars),
        .m_sat_chars(m_sat_chars),
        .m_lock_state(m_lock_state)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    initial begin
        #(12 * 400000);
        $display("nmea_gga_gsa_field_extractor_unit_tb failed");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_result_kind, m_time_chars, m_sat_chars, m_lock_state);
    end

    // Receiver: random stalls, one long hold-off, and a steady stretch.
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (steady) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 35);
            end
        end
    end

    task automatic plan_text(input string s);
        for (int i = 0; i < s.len(); i++)
            byte_plan.push_back(s[i]);
    endtask

    // Field content: mostly digits, sometimes any byte that is not a delimiter.
    task automatic plan_field(input int len);
        logic [7:0] c;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(3) == 0) begin
                do c = 8'($urandom_range(255));
                while (c == ngfx_pkg::CHAR_NEWLINE || c == ngfx_pkg::CHAR_DOLLAR ||
                       c == ngfx_pkg::CHAR_COMMA);
            end else begin
                c = ngfx_pkg::DIGIT_BIAS + 8'($urandom_range(9));
            end
            byte_plan.push_back(c);
        end
    endtask

    task automatic plan_sentence(input bit field_wrap);
        int pick;
        pick = $urandom_range(99);
        if (field_wrap) begin
            // Enough commas to wrap the field count back onto the time field.
            byte_plan.push_back(ngfx_pkg::CHAR_NEWLINE);
            plan_text("$GPGGA,");
            repeat (256) byte_plan.push_back(ngfx_pkg::CHAR_COMMA);
            plan_text("123,9");
            byte_plan.push_back(ngfx_pkg::CHAR_NEWLINE);
        end else if (pick < 40) begin
            plan_text("$GPGGA,");
            if ($urandom_range(9) == 0)
                byte_plan.push_back(ngfx_pkg::CHAR_G);
            plan_field(($urandom_range(4) != 0) ? 6 : $urandom_range(18));
            byte_plan.push_back(ngfx_pkg::CHAR_COMMA);
            plan_field($urandom_range(3));
            repeat (5) begin
                byte_plan.push_back(ngfx_pkg::CHAR_COMMA);
                plan_field($urandom_range(2));
            end
            plan_field(($urandom_range(7) == 0) ? $urandom_range(12) : $urandom_range(2));
            byte_plan.push_back(ngfx_pkg::CHAR_COMMA);
            plan_field($urandom_range(3));
            repeat ($urandom_range(3)) begin
                byte_plan.push_back(ngfx_pkg::CHAR_COMMA);
                plan_field($urandom_range(3));
            end
            if ($urandom_range(9) != 0)
                byte_plan.push_back(ngfx_pkg::CHAR_NEWLINE);
        end else if (pick < 65) begin
            plan_text($urandom_range(1) ? "$GPGSA,A," : "$GPGSA,M,");
            if ($urandom_range(4) != 0)
                byte_plan.push_back(ngfx_pkg::DIGIT_BIAS + 8'($urandom_range(1, 3)));
            else
                plan_field($urandom_range(2));
            plan_field($urandom_range(1));
            repeat ($urandom_range(3)) begin
                byte_plan.push_back(ngfx_pkg::CHAR_COMMA);
                plan_field($urandom_range(2));
            end
            if ($urandom_range(9) != 0)
                byte_plan.push_back(ngfx_pkg::CHAR_NEWLINE);
        end else if (pick < 80) begin
            // Unknown, near-miss or overlong command.
            case ($urandom_range(3))
                0: plan_text("$GPGTA");
                1: plan_text("$GPGGB");
                2: plan_text("$GNGSA");
                default: begin
                    byte_plan.push_back(ngfx_pkg::CHAR_DOLLAR);
                    repeat ($urandom_range(20))
                        byte_plan.push_back(ngfx_pkg::CHAR_A + 8'($urandom_range(25)));
                end
            endcase
            byte_plan.push_back(ngfx_pkg::CHAR_COMMA);
            plan_field($urandom_range(4));
            byte_plan.push_back(ngfx_pkg::CHAR_NEWLINE);
        end else begin
            repeat ($urandom_range(1, 20))
                byte_plan.push_back(8'($urandom_range(255)));
        end
    endtask

    task automatic offer_byte(input logic [7:0] b, input bit drain_first);
        if (drain_first || (!steady && $urandom_range(99) < 35)) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while (drain_first && board.pending() != 0)
                @(posedge aclk);
            while (!steady && $urandom_range(99) < 35)
                @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        board.note_input(b);
    endtask

    initial begin
        int sent;
        bit wrap_done;
        board = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_rx_byte = '0;
        steady = 1'b0;
        hold_request = 1'b0;
        sent = 0;
        wrap_done = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Byte extremes, a comma while idle, a good and a bad fix digit.
        byte_plan.push_back(8'h00);
        byte_plan.push_back(8'hFF);
        plan_text(",$GPGSA,A,3");
        byte_plan.push_back(ngfx_pkg::CHAR_NEWLINE);
        plan_text("$GPGSA,A,7");
        byte_plan.push_back(ngfx_pkg::CHAR_NEWLINE);
        while (byte_plan.size() != 0)
            offer_byte(byte_plan.pop_front(), 1'b0);

        while (sent < RANDOM_ITEMS) begin
            if (byte_plan.size() == 0) begin
                plan_sentence(sent >= 300 && !wrap_done);
                if (sent >= 300)
                    wrap_done = 1'b1;
            end
            offer_byte(byte_plan.pop_front(), sent == 0 || sent == 700);
            sent++;
            if (sent == 400)
                hold_request <= 1'b1;
            steady <= (sent >= 500 && sent < 650);
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("nmea_gga_gsa_field_extractor_unit_tb passed");
        else
            $display("nmea_gga_gsa_field_extractor_unit_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
